// ===== rtl/rgb_to_hsv_converter_defines.svh =====
// ----------------------------------------------------------------------------
// RGB to HSV converter: assertion macros
// Shared property wrappers for the converter RTL. They sample on aclk and
// stay quiet while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef RGB_TO_HSV_CONVERTER_DEFINES_SVH
`define RGB_TO_HSV_CONVERTER_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter package
// Request types, divider types and fixed constants shared by the converter.
// ----------------------------------------------------------------------------
`default_nettype none

package rhc_pkg;

    localparam int RGB_W     = 8;
    localparam int HUE_W     = 15;
    localparam int FRAC_W    = 17;
    // quotient bits produced by the divider, one per stage
    localparam int DIV_STEPS = 16;
    // hue of one sector (60 degrees) in 1/64 degree
    localparam logic [11:0] HUE_SCALE = 12'd3840;
    localparam int HNUM_W    = 22;

    // input request: one pixel
    typedef struct packed {
        logic [RGB_W-1:0] red;
        logic [RGB_W-1:0] green;
        logic [RGB_W-1:0] blue;
    } rhc_pixel_t;

    // result request: one HSV triple
    typedef struct packed {
        logic signed [HUE_W-1:0] hue;
        logic [FRAC_W-1:0]       saturation;
        logic [FRAC_W-1:0]       brightness;
        logic                    hue_undefined;
    } rhc_hsv_t;

    // one stage of the restoring divider: partial remainder, dividend bits
    // still to be consumed (high end) with quotient bits shifted in (low end)
    typedef struct packed {
        logic [RGB_W-1:0]     rem;
        logic [DIV_STEPS-1:0] work;
        logic [RGB_W-1:0]     divisor;
    } rhc_div_t;

endpackage

`default_nettype wire

// ===== rtl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter
// Pipelined conversion of 8-bit RGB pixels to hue, saturation and value.
// ----------------------------------------------------------------------------
// The converter takes one pixel per clock while s_ready is high and returns
// one HSV result per pixel, in order. Four front stages (A to D) find max/min,
// the sector numerator and the scaled hue dividend. Two 16-stage restoring
// dividers (one quotient bit per stage) then form saturation and hue side by
// side, and that divider depth sets the latency; the output register comes
// last and drives m_valid. Brightness needs no divider. A two-entry output
// buffer lets the pipeline keep taking a pixel while a result waits; s_ready
// falls only once both entries hold results. Write cfg_wdata (the hue reported
// for grey pixels) only while no pixel is in flight.
`default_nettype none
`include "rgb_to_hsv_converter_defines.svh"

module rgb_to_hsv_converter
    import rhc_pkg::*;
(
    input  var logic                    aclk,
    input  var logic                    aresetn,
    input  var logic                    s_valid,
    output logic                        s_ready,
    input  var rhc_pixel_t              s_data,
    output logic                        m_valid,
    input  var logic                    m_ready,
    output rhc_hsv_t                    m_data,
    input  var logic                    cfg_wen,
    input  var logic signed [HUE_W-1:0] cfg_wdata
);

    typedef struct packed {
        logic               neg;
        logic               undef;
        logic               full;
        logic [FRAC_W-1:0]  brightness;
    } rhc_side_t;

    logic                    adv;
    logic signed [HUE_W-1:0] undef_hue_reg;

    // stage A: captured pixel
    logic       a_valid_reg;
    rhc_pixel_t a_pix_reg;

    // stage B: extremes and winning channel
    logic             b_valid_reg;
    rhc_pixel_t       b_pix_reg;
    logic [RGB_W-1:0] b_mx_reg;
    logic [RGB_W-1:0] b_delta_reg;
    logic             b_rmax_reg;
    logic             b_gmax_reg;
    logic [RGB_W-1:0] b_mx_next;
    logic [RGB_W-1:0] b_mn_next;
    logic             b_rmax_next;
    logic             b_gmax_next;

    // stage C: wrapped sector numerator
    logic              c_valid_reg;
    logic [RGB_W-1:0]  c_mx_reg;
    logic [RGB_W-1:0]  c_delta_reg;
    logic [9:0]        c_mag_reg;
    rhc_side_t         c_side_reg;
    logic signed [11:0] d12;
    logic signed [11:0] r12;
    logic signed [11:0] g12;
    logic signed [11:0] b12;
    logic signed [11:0] n_raw;
    logic signed [11:0] n_wrap;
    logic [11:0]        n_abs;

    // stage D: hue dividend
    logic              d_valid_reg;
    logic [RGB_W-1:0]  d_mx_reg;
    logic [RGB_W-1:0]  d_delta_reg;
    logic [HNUM_W-1:0] d_hnum_reg;
    rhc_side_t         d_side_reg;
    logic [HNUM_W-1:0] d_hnum_next;

    // divider stages
    logic [DIV_STEPS-1:0] dv_reg;
    rhc_side_t            side_reg [0:DIV_STEPS-1];
    rhc_div_t             sat_div_in;
    rhc_div_t             hue_div_in;
    logic [DIV_STEPS-1:0] sat_q;
    logic [DIV_STEPS-1:0] hue_q;

    // output buffer
    rhc_hsv_t res_next;
    logic     p_valid;
    logic     out_free;
    logic     m_valid_reg;
    rhc_hsv_t m_data_reg;
    logic     skid_valid_reg;
    rhc_hsv_t skid_data_reg;

    // Move the whole pipeline unless the spare output entry is taken.
    assign adv     = !skid_valid_reg;
    assign s_ready = adv;

    // Hold the grey-pixel hue.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            undef_hue_reg <= '0;
        end else if (cfg_wen) begin
            undef_hue_reg <= cfg_wdata;
        end
    end

    // Stage A: capture the request.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && s_valid) begin
            a_pix_reg <= s_data;
        end
    end

    // Stage B: find max and min; red wins ties, then green.
    always_comb begin
        b_rmax_next = (a_pix_reg.red >= a_pix_reg.green) && (a_pix_reg.red >= a_pix_reg.blue);
        b_gmax_next = !b_rmax_next && (a_pix_reg.green >= a_pix_reg.blue);
        priority if (b_rmax_next) begin
            b_mx_next = a_pix_reg.red;
        end else if (b_gmax_next) begin
            b_mx_next = a_pix_reg.green;
        end else begin
            b_mx_next = a_pix_reg.blue;
        end
        b_mn_next = a_pix_reg.red;
        if (a_pix_reg.green < b_mn_next) begin
            b_mn_next = a_pix_reg.green;
        end
        if (a_pix_reg.blue < b_mn_next) begin
            b_mn_next = a_pix_reg.blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_pix_reg   <= a_pix_reg;
            b_mx_reg    <= b_mx_next;
            b_delta_reg <= b_mx_next - b_mn_next;
            b_rmax_reg  <= b_rmax_next;
            b_gmax_reg  <= b_gmax_next;
        end
    end

    // Stage C: sector numerator, wrapped into (-3*delta, 3*delta].
    always_comb begin
        d12 = $signed({4'b0, b_delta_reg});
        r12 = $signed({4'b0, b_pix_reg.red});
        g12 = $signed({4'b0, b_pix_reg.green});
        b12 = $signed({4'b0, b_pix_reg.blue});
        priority if (b_rmax_reg) begin
            n_raw = g12 - b12;
        end else if (b_gmax_reg) begin
            n_raw = (d12 <<< 1) + b12 - r12;
        end else begin
            n_raw = (d12 <<< 2) + r12 - g12;
        end
        if (n_raw > (d12 + (d12 <<< 1))) begin
            n_wrap = n_raw - ((d12 <<< 2) + (d12 <<< 1));
        end else begin
            n_wrap = n_raw;
        end
        n_abs = n_wrap[11] ? 12'(-n_wrap) : 12'(n_wrap);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            c_mx_reg              <= b_mx_reg;
            c_delta_reg           <= b_delta_reg;
            c_mag_reg             <= n_abs[9:0];
            c_side_reg.neg        <= n_wrap[11];
            c_side_reg.undef      <= (b_delta_reg == '0);
            // a zero channel makes delta equal max: full saturation
            c_side_reg.full       <= (b_delta_reg == b_mx_reg);
            // max*65536/255 rounded is max*257 plus one for the upper half
            c_side_reg.brightness <= {1'b0, b_mx_reg, b_mx_reg}
                                     + {{(FRAC_W-1){1'b0}}, b_mx_reg[RGB_W-1]};
        end
    end

    // Stage D: hue dividend 3840*|n| + delta/2 for round to nearest.
    assign d_hnum_next = HNUM_W'(c_mag_reg) * HNUM_W'(HUE_SCALE)
                         + HNUM_W'(c_delta_reg[RGB_W-1:1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_mx_reg    <= c_mx_reg;
            d_delta_reg <= c_delta_reg;
            d_hnum_reg  <= d_hnum_next;
            d_side_reg  <= c_side_reg;
        end
    end

    // Saturation: (delta*65536 + max/2) / max. Delta equal to max gives
    // exactly 65536, which the quotient cannot hold; those pixels bypass it.
    assign sat_div_in.rem     = d_side_reg.full ? '0 : d_delta_reg;
    assign sat_div_in.work    = DIV_STEPS'(d_mx_reg[RGB_W-1:1]);
    assign sat_div_in.divisor = d_mx_reg;

    // Hue: dividend / delta; the dividend stays below delta * 2^14.
    assign hue_div_in.rem     = RGB_W'(d_hnum_reg[HNUM_W-1:DIV_STEPS]);
    assign hue_div_in.work    = d_hnum_reg[DIV_STEPS-1:0];
    assign hue_div_in.divisor = d_delta_reg;

    rhc_div_pipe u_sat_div (
        .aclk     (aclk),
        .en       (adv),
        .div_in   (sat_div_in),
        .quotient (sat_q)
    );

    rhc_div_pipe u_hue_div (
        .aclk     (aclk),
        .en       (adv),
        .div_in   (hue_div_in),
        .quotient (hue_q)
    );

    // Carry valid and side data alongside the divider stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg <= '0;
        end else if (adv) begin
            dv_reg <= {dv_reg[DIV_STEPS-2:0], d_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= d_side_reg;
        end
    end

    for (genvar k = 1; k < DIV_STEPS; k++) begin : g_side
        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    // Form the result; grey pixels take the configured hue.
    always_comb begin
        res_next.brightness    = side_reg[DIV_STEPS-1].brightness;
        res_next.hue_undefined = side_reg[DIV_STEPS-1].undef;
        if (side_reg[DIV_STEPS-1].undef) begin
            res_next.hue        = undef_hue_reg;
            res_next.saturation = '0;
        end else begin
            res_next.saturation = side_reg[DIV_STEPS-1].full ? {1'b1, {(FRAC_W-1){1'b0}}}
                                                             : FRAC_W'(sat_q);
            res_next.hue = side_reg[DIV_STEPS-1].neg ? $signed(HUE_W'(-hue_q))
                                                     : $signed(hue_q[HUE_W-1:0]);
        end
    end

    assign p_valid  = adv && dv_reg[DIV_STEPS-1];
    assign out_free = !m_valid_reg || m_ready;

    // Output register with a spare entry: drain the spare first.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg    <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            if (skid_valid_reg) begin
                m_valid_reg    <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                m_valid_reg <= p_valid;
            end
        end else if (p_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                m_data_reg <= skid_data_reg;
            end else if (p_valid) begin
                m_data_reg <= res_next;
            end
        end else if (p_valid) begin
            skid_data_reg <= res_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `RHC_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, m_valid_reg, "spare entry full while output empty")
    `RHC_ASSERT_NOW(a_grey_zero_sat, m_valid_reg && m_data_reg.hue_undefined, m_data_reg.saturation == '0, "grey pixel with nonzero saturation")
    `RHC_ASSERT_NOW(a_hue_range, m_valid_reg && !m_data_reg.hue_undefined, (m_data_reg.hue >= -15'sd11519) && (m_data_reg.hue <= 15'sd11520), "hue outside (-180,180] degrees")
    `RHC_ASSERT_NEXT(a_stall_to_skid, m_valid_reg && !m_ready && p_valid, skid_valid_reg, "stalled result not parked in spare entry")

endmodule

`default_nettype wire

// ===== rtl/rhc_div_pipe.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter: pipelined divider
// Restoring division with one quotient bit per register stage. The starting
// remainder must be below the divisor; the quotient then fits DIV_STEPS bits.
// ----------------------------------------------------------------------------
`default_nettype none

module rhc_div_pipe
    import rhc_pkg::*;
(
    input  var logic                 aclk,
    input  var logic                 en,
    input  var rhc_div_t             div_in,
    output logic [DIV_STEPS-1:0]     quotient
);

    // Shift in one dividend bit, subtract the divisor when it fits.
    function automatic rhc_div_t div_step(input rhc_div_t x);
        logic [RGB_W:0]   trial;
        logic [RGB_W:0]   diff;
        logic             fits;
        rhc_div_t         y;
        trial = {x.rem, x.work[DIV_STEPS-1]};
        diff  = trial - {1'b0, x.divisor};
        fits  = (trial >= {1'b0, x.divisor});
        y.divisor = x.divisor;
        y.rem     = fits ? diff[RGB_W-1:0] : trial[RGB_W-1:0];
        y.work    = {x.work[DIV_STEPS-2:0], fits};
        return y;
    endfunction

    rhc_div_t stage_reg [0:DIV_STEPS-1];

    // Advance every stage together when the pipeline moves.
    always_ff @(posedge aclk) begin
        if (en) begin
            stage_reg[0] <= div_step(div_in);
        end
    end

    for (genvar k = 1; k < DIV_STEPS; k++) begin : g_stage
        always_ff @(posedge aclk) begin
            if (en) begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
        end
    end

    assign quotient = stage_reg[DIV_STEPS-1].work;

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// ----------------------------------------------------------------------------
// RGB to HSV converter testbench
// Sends pixels over the valid/ready input channel and predicts each HSV
// result in the testbench. Every result is checked in order against the
// prediction while each side stalls at random or runs steady. The grey hue
// register is covered at reset, at both ends of its range and outside it.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhc_pkg::*;

    logic                    aclk;
    logic                    aresetn;
    logic                    s_valid;
    logic                    s_ready;
    rhc_pixel_t              s_data;
    logic                    m_valid;
    logic                    m_ready;
    rhc_hsv_t                m_data;
    logic                    cfg_wen;
    logic signed [HUE_W-1:0] cfg_wdata;

    // testbench copy of the grey hue register
    logic signed [HUE_W-1:0] grey_hue_model;
    // HSV results still owed by the converter, oldest first
    rhc_hsv_t                pending_hsv[$];
    int                      errors;
    bit                      src_steady;
    bit                      sink_steady;
    int                      sink_hold;
    int                      sink_pick;

    rgb_to_hsv_converter DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    // Compute the HSV triple of one pixel.
    function automatic rhc_hsv_t hsv_of(rhc_pixel_t px, logic signed [HUE_W-1:0] grey_hue);
        int r, g, b, mx, mn, delta, n, mag, q;
        rhc_hsv_t res;
        r = px.red;
        g = px.green;
        b = px.blue;
        mx = r;
        mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        res.brightness = FRAC_W'((mx * 131072 + 255) / 510);
        if (mx == mn) begin
            res.hue           = grey_hue;
            res.saturation    = '0;
            res.hue_undefined = 1'b1;
        end else begin
            delta = mx - mn;
            res.saturation = FRAC_W'((delta * 131072 + mx) / (mx * 2));
            // red wins ties, then green
            if (r == mx)
                n = g - b;
            else if (g == mx)
                n = 2 * delta + (b - r);
            else
                n = 4 * delta + (r - g);
            // wrap above 180 degrees on the exact value
            if (n > 3 * delta)
                n = n - 6 * delta;
            mag = (n < 0) ? -n : n;
            q = (3840 * mag * 2 + delta) / (delta * 2);
            if (n < 0)
                q = -q;
            res.hue           = HUE_W'(q);
            res.hue_undefined = 1'b0;
        end
        return res;
    endfunction

    // Pick an idle gap: mostly none or short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (src_steady || r < 50)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 20);
    endfunction

    // Draw a pixel, biased toward grey, ties and channel extremes.
    function automatic rhc_pixel_t random_pixel();
        rhc_pixel_t px;
        int kind;
        logic [7:0] corner [4];
        corner[0] = 8'd0;
        corner[1] = 8'd1;
        corner[2] = 8'd254;
        corner[3] = 8'd255;
        kind = $urandom_range(0, 9);
        px.red   = 8'($urandom);
        px.green = 8'($urandom);
        px.blue  = 8'($urandom);
        case (kind)
            0: begin
                px.green = px.red;
                px.blue  = px.red;
            end
            1: px.green = px.red;
            2: px.blue = px.red;
            3: px.blue = px.green;
            4: begin
                px.red   = corner[$urandom_range(0, 3)];
                px.green = corner[$urandom_range(0, 3)];
                px.blue  = corner[$urandom_range(0, 3)];
            end
            default: ;
        endcase
        return px;
    endfunction

    // Record each accepted request and check each delivered result.
    always @(posedge aclk) begin
        rhc_hsv_t exp_hsv;
        if (aresetn && s_valid && s_ready)
            pending_hsv.push_back(hsv_of(s_data, grey_hue_model));
        if (aresetn && m_valid && m_ready) begin
            if (pending_hsv.size() == 0) begin
                errors++;
                $display("%0t: unexpected result hue %0d sat %0d val %0d undef %0b",
                         $time, m_data.hue, m_data.saturation, m_data.brightness,
                         m_data.hue_undefined);
            end else begin
                exp_hsv = pending_hsv.pop_front();
                if (m_data !== exp_hsv) begin
                    errors++;
                    $display("%0t: expected hue %0d sat %0d val %0d undef %0b, got hue %0d sat %0d val %0d undef %0b",
                             $time, exp_hsv.hue, exp_hsv.saturation, exp_hsv.brightness,
                             exp_hsv.hue_undefined, m_data.hue, m_data.saturation,
                             m_data.brightness, m_data.hue_undefined);
                end
            end
        end
    end

    // Drive result backpressure: steady ready, or random stalls.
    always @(posedge aclk) begin
        if (sink_hold > 0) begin
            sink_hold = sink_hold - 1;
        end else if (sink_steady) begin
            m_ready <= 1'b1;
        end else begin
            sink_pick = $urandom_range(0, 99);
            if (sink_pick < 60) begin
                m_ready <= 1'b1;
                sink_hold = $urandom_range(0, 7);
            end else if (sink_pick < 90) begin
                m_ready <= 1'b0;
                sink_hold = $urandom_range(0, 2);
            end else begin
                m_ready <= 1'b0;
                sink_hold = $urandom_range(4, 24);
            end
        end
    end

    // Send one pixel request and hold it until accepted.
    task automatic send_pixel(input rhc_pixel_t px);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= px;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic send_rgb(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
        rhc_pixel_t px;
        px.red   = r;
        px.green = g;
        px.blue  = b;
        send_pixel(px);
    endtask

    // Drop valid and wait until every result is back and the pipe is empty.
    // The first edge lets the last accepted request reach the queue.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_hsv.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
    endtask

    task automatic write_grey_hue(input logic signed [HUE_W-1:0] v);
        settle();
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        grey_hue_model = v;
        cfg_wen <= 1'b0;
    endtask

    // Grey pixels right after reset report the reset hue of zero.
    task automatic test_reset_hue();
        send_rgb(8'd0, 8'd0, 8'd0);
        send_rgb(8'd255, 8'd255, 8'd255);
        send_rgb(8'd128, 8'd128, 8'd128);
    endtask

    // Primaries, secondaries, tie order, exact 180 degrees and near wrap.
    task automatic test_hue_sectors();
        send_rgb(8'd255, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd255);
        send_rgb(8'd255, 8'd255, 8'd0);
        send_rgb(8'd0, 8'd255, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd255);
        send_rgb(8'd1, 8'd0, 8'd0);
        send_rgb(8'd0, 8'd0, 8'd1);
        send_rgb(8'd0, 8'd254, 8'd255);
        send_rgb(8'd1, 8'd0, 8'd255);
        send_rgb(8'd255, 8'd0, 8'd1);
        send_rgb(8'd254, 8'd255, 8'd1);
        send_rgb(8'd200, 8'd200, 8'd100);
        send_rgb(8'd100, 8'd200, 8'd200);
    endtask

    // Grey hue at the range ends and outside it; colors must ignore it.
    task automatic test_grey_register();
        logic signed [HUE_W-1:0] vals [6];
        vals[0] = -15'sd11520;
        vals[1] = 15'sd11520;
        vals[2] = -15'sd16384;
        vals[3] = 15'sd16383;
        vals[4] = 15'sd10922;
        vals[5] = -15'sd10923;
        foreach (vals[i]) begin
            write_grey_hue(vals[i]);
            send_rgb(8'(i * 40), 8'(i * 40), 8'(i * 40));
            if (i % 2 == 0)
                send_rgb(8'd255, 8'd255, 8'd255);
        end
        send_rgb(8'd10, 8'd20, 8'd30);
    endtask

    // Random pixels in phases, each with its own grey hue and pacing.
    task automatic test_random_pixels();
        for (int phase = 0; phase < 7; phase++) begin
            if (phase == 6)
                write_grey_hue('0);
            else
                write_grey_hue(HUE_W'($urandom));
            src_steady  = (phase % 3 == 1);
            sink_steady = (phase % 3 == 2);
            repeat (200) send_pixel(random_pixel());
        end
        src_steady  = 1'b0;
        sink_steady = 1'b0;
    endtask

    initial begin
        aclk           = 1'b0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_data         = '0;
        m_ready        = 1'b0;
        cfg_wen        = 1'b0;
        cfg_wdata      = '0;
        grey_hue_model = '0;
        errors         = 0;
        src_steady     = 1'b0;
        sink_steady    = 1'b0;
        sink_hold      = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_hue();
        test_hue_sectors();
        test_grey_register();
        test_random_pixels();

        settle();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Stop a hung run.
    initial begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
